// ===== src/cerq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cerq_pkg: shared types and constants for the coalescing event ring queue
// Command and status codes, the stored entry layout and the front/back
// command record.
// ----------------------------------------------------------------------------
package cerq_pkg;

  localparam int unsigned QueueDepthDefault = 4096;
  localparam int unsigned CountWidth        = 12;

  typedef enum logic [2:0] {
    CMD_PUSH   = 3'd0,
    CMD_POP    = 3'd1,
    CMD_CLEAR  = 3'd2,
    CMD_RSTCNT = 3'd3,
    CMD_STATUS = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    ST_APPENDED  = 3'd0,
    ST_COALESCED = 3'd1,
    ST_DROPPED   = 3'd2,
    ST_POPPED    = 3'd3,
    ST_EMPTY     = 3'd4,
    ST_DONE      = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    OP_PUSH_SCAN,
    OP_PUSH_PLAIN,
    OP_POP,
    OP_CLEAR,
    OP_RSTCNT,
    OP_NOP
  } op_e;

  typedef struct packed {
    logic [63:0] ev_time;
    logic [15:0] ev_size;
    logic [31:0] ev_window;
    logic [7:0]  ev_type;
  } entry_t;

  // classified command handed from front to back
  typedef struct packed {
    op_e    op;
    entry_t ev;
  } job_t;

  localparam int unsigned JobWidth = $bits(job_t);

  localparam int unsigned RegMotionType = 0;
  localparam int unsigned RegCoalesceEn = 1;

endpackage

// ===== src/cerq_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cerq_front: command intake and classification
// Decodes each command against the current configuration and queues a job
// record in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module cerq_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  input  logic [2:0]        cmd_i,
  input  cerq_pkg::entry_t  ev_i,
  input  logic [7:0]        motion_type_i,
  input  logic              coalesce_en_i,
  output logic              j_valid_o,
  input  logic              j_ready_i,
  output cerq_pkg::job_t    job_o
);

  cerq_pkg::job_t job_q [2];
  logic           rd_q, wr_q;
  logic [1:0]     cnt_q;
  cerq_pkg::job_t job_in;
  logic           push, pop;

  always_comb begin
    job_in.ev = ev_i;
    unique case (cmd_i)
      cerq_pkg::CMD_PUSH:
        job_in.op = (coalesce_en_i && ev_i.ev_type == motion_type_i)
                    ? cerq_pkg::OP_PUSH_SCAN : cerq_pkg::OP_PUSH_PLAIN;
      cerq_pkg::CMD_POP:    job_in.op = cerq_pkg::OP_POP;
      cerq_pkg::CMD_CLEAR:  job_in.op = cerq_pkg::OP_CLEAR;
      cerq_pkg::CMD_RSTCNT: job_in.op = cerq_pkg::OP_RSTCNT;
      default:              job_in.op = cerq_pkg::OP_NOP;
    endcase
  end

  assign s_ready_o = (cnt_q != 2'd2);
  assign j_valid_o = (cnt_q != 2'd0);
  assign job_o     = job_q[rd_q];
  assign push      = s_valid_i && s_ready_o;
  assign pop       = j_valid_o && j_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) job_q[wr_q] <= job_in;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== src/cerq_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cerq_back: ring storage and command execution
// Holds the event memory, indexes and counters; walks the motion run backward
// one entry at a time, reading then comparing, for coalescing pushes.
// ----------------------------------------------------------------------------
module cerq_back #(
  parameter int unsigned QueueDepth = cerq_pkg::QueueDepthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              j_valid_i,
  output logic              j_ready_o,
  input  cerq_pkg::job_t    job_i,
  input  logic [7:0]        motion_type_i,
  output logic              r_valid_o,
  input  logic              r_ready_i,
  output logic [2:0]        status_o,
  output cerq_pkg::entry_t  out_ev_o,
  output logic [cerq_pkg::CountWidth-1:0] count_o,
  output logic [63:0]       coal_tot_o,
  output logic [63:0]       drop_tot_o
);

  localparam int unsigned AW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam logic [AW-1:0] Last = AW'(QueueDepth - 1);
  localparam int unsigned CW = cerq_pkg::CountWidth;

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_CMP, S_APP, S_POPRD, S_OUT
  } state_e;

  state_e           state_q;
  cerq_pkg::job_t   job_q;
  logic [AW-1:0]    wr_q, rd_q, scan_q;
  logic [63:0]      coal_q, drop_q;
  cerq_pkg::entry_t mem [QueueDepth];
  cerq_pkg::entry_t rdata_q;
  logic             r_valid_q;
  logic [2:0]       status_q;
  cerq_pkg::entry_t out_ev_q;
  logic             mem_we;
  logic [AW-1:0]    mem_wa, mem_ra;
  logic             mem_re;
  logic [AW-1:0]    wr_inc, rd_inc, scan_dec, occ;

  function automatic logic [AW-1:0] inc(input logic [AW-1:0] i);
    return (i == Last) ? '0 : i + 1'b1;
  endfunction

  assign wr_inc   = inc(wr_q);
  assign rd_inc   = inc(rd_q);
  assign scan_dec = (scan_q == '0) ? Last : scan_q - 1'b1;
  assign occ      = (wr_q >= rd_q) ? wr_q - rd_q : AW'(wr_q + Last - rd_q + 1'b1);

  assign j_ready_o  = (state_q == S_IDLE) && !r_valid_q;
  assign r_valid_o  = r_valid_q;
  assign status_o   = status_q;
  assign out_ev_o   = out_ev_q;
  assign count_o    = CW'(occ);
  assign coal_tot_o = coal_q;
  assign drop_tot_o = drop_q;

  always_comb begin
    mem_we = 1'b0;
    mem_wa = wr_q;
    mem_re = 1'b0;
    mem_ra = scan_q;
    unique case (state_q)
      S_RD:    mem_re = 1'b1;
      S_POPRD: begin
        mem_re = 1'b1;
        mem_ra = rd_q;
      end
      S_CMP: begin
        if (rdata_q.ev_type == motion_type_i &&
            rdata_q.ev_window == job_q.ev.ev_window) begin
          mem_we = 1'b1;
          mem_wa = scan_q;
        end
      end
      S_APP:   mem_we = (wr_inc != rd_q);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= job_q.ev;
    if (mem_re) rdata_q <= mem[mem_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      job_q     <= '0;
      wr_q      <= '0;
      rd_q      <= '0;
      scan_q    <= '0;
      coal_q    <= '0;
      drop_q    <= '0;
      r_valid_q <= 1'b0;
      status_q  <= cerq_pkg::ST_DONE;
      out_ev_q  <= '0;
    end else begin
      if (r_valid_q && r_ready_i) r_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (j_valid_i && j_ready_o) begin
            job_q    <= job_i;
            out_ev_q <= '0;
            status_q <= cerq_pkg::ST_DONE;
            scan_q   <= (wr_q == '0) ? Last : wr_q - 1'b1;
            unique case (job_i.op)
              cerq_pkg::OP_PUSH_SCAN:
                state_q <= (wr_q != rd_q) ? S_RD : S_APP;
              cerq_pkg::OP_PUSH_PLAIN: state_q <= S_APP;
              cerq_pkg::OP_POP: begin
                if (wr_q == rd_q) begin
                  status_q  <= cerq_pkg::ST_EMPTY;
                  r_valid_q <= 1'b1;
                end else begin
                  state_q <= S_POPRD;
                end
              end
              cerq_pkg::OP_CLEAR: begin
                rd_q      <= wr_q;
                r_valid_q <= 1'b1;
              end
              cerq_pkg::OP_RSTCNT: begin
                coal_q    <= '0;
                drop_q    <= '0;
                r_valid_q <= 1'b1;
              end
              default: r_valid_q <= 1'b1;
            endcase
          end
        end
        S_RD: state_q <= S_CMP;
        S_CMP: begin
          priority if (rdata_q.ev_type != motion_type_i) begin
            state_q <= S_APP;
          end else if (rdata_q.ev_window == job_q.ev.ev_window) begin
            coal_q    <= coal_q + 64'd1;
            status_q  <= cerq_pkg::ST_COALESCED;
            r_valid_q <= 1'b1;
            state_q   <= S_IDLE;
          end else if (scan_q == rd_q) begin
            state_q <= S_APP;
          end else begin
            scan_q  <= scan_dec;
            state_q <= S_RD;
          end
        end
        S_APP: begin
          if (wr_inc == rd_q) begin
            drop_q   <= drop_q + 64'd1;
            status_q <= cerq_pkg::ST_DROPPED;
          end else begin
            wr_q     <= wr_inc;
            status_q <= cerq_pkg::ST_APPENDED;
          end
          r_valid_q <= 1'b1;
          state_q   <= S_IDLE;
        end
        S_POPRD: state_q <= S_OUT;
        S_OUT: begin
          out_ev_q  <= rdata_q;
          rd_q      <= rd_inc;
          status_q  <= cerq_pkg::ST_POPPED;
          r_valid_q <= 1'b1;
          state_q   <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== src/coalescing_event_ring_queue_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coalescing_event_ring_queue_unit: event ring FIFO with motion coalescing
//
// channel | dir | handshake            | contents
// s_axis  | in  | s_axis_tvalid/tready | cmd, event fields
// m_axis  | out | m_axis_tvalid/tready | status, popped event, count, totals
// cfg     | in  | cfg_valid_i/ready_o  | register index, write data
//
// Clear, counter reset, status and empty pop answer from idle; a plain push goes
// through the append state, a pop through the memory read and output states.
// A scanning push reads then compares each scanned entry (one memory read
// port) and ends in the append state for an append or drop. The back end
// takes the next command only after the result transfer. Reset zeroes indexes
// and counters and restores configuration defaults; memory is not cleared.
// A two-entry command queue lets intake continue while the back end stalls
// on an untaken result.
// ----------------------------------------------------------------------------
module coalescing_event_ring_queue_unit #(
  parameter int unsigned QueueDepth = cerq_pkg::QueueDepthDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // cmd[2:0], ev_type[10:3], ev_window[42:11], ev_size[58:43], ev_time[122:59]
  input  logic [127:0]  s_axis_tdata,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // status[2:0], out_type[10:3], out_window[42:11], out_size[58:43],
  // out_time[122:59], entry_count[134:123], coalesced_total[198:135],
  // dropped_total[262:199]
  output logic [263:0]  m_axis_tdata,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [0:0]    cfg_index_i,
  input  logic [7:0]    cfg_data_i
);

  logic [7:0]              motion_q;
  logic                    coal_en_q;
  logic                    j_valid, j_ready, r_valid;
  cerq_pkg::job_t          job;
  cerq_pkg::entry_t        ev_in, out_ev;
  logic [2:0]              status;
  logic [cerq_pkg::CountWidth-1:0] count;
  logic [63:0]             coal_tot, drop_tot;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      motion_q  <= 8'd1;
      coal_en_q <= 1'b1;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == 1'(cerq_pkg::RegMotionType)) motion_q <= cfg_data_i;
      else coal_en_q <= cfg_data_i[0];
    end
  end

  assign ev_in.ev_type   = s_axis_tdata[10:3];
  assign ev_in.ev_window = s_axis_tdata[42:11];
  assign ev_in.ev_size   = s_axis_tdata[58:43];
  assign ev_in.ev_time   = s_axis_tdata[122:59];

  cerq_front u_front (
    .clk_i, .rst_ni,
    .s_valid_i     (s_axis_tvalid),
    .s_ready_o     (s_axis_tready),
    .cmd_i         (s_axis_tdata[2:0]),
    .ev_i          (ev_in),
    .motion_type_i (motion_q),
    .coalesce_en_i (coal_en_q),
    .j_valid_o     (j_valid),
    .j_ready_i     (j_ready),
    .job_o         (job)
  );

  cerq_back #(.QueueDepth(QueueDepth)) u_back (
    .clk_i, .rst_ni,
    .j_valid_i     (j_valid),
    .j_ready_o     (j_ready),
    .job_i         (job),
    .motion_type_i (motion_q),
    .r_valid_o     (r_valid),
    .r_ready_i     (m_axis_tready),
    .status_o      (status),
    .out_ev_o      (out_ev),
    .count_o       (count),
    .coal_tot_o    (coal_tot),
    .drop_tot_o    (drop_tot)
  );

  assign m_axis_tvalid = r_valid;
  assign m_axis_tdata  = {1'b0, drop_tot, coal_tot, count, out_ev.ev_time,
                          out_ev.ev_size, out_ev.ev_window, out_ev.ev_type, status};

endmodule

// ===== verif/tb_coalescing_event_ring_queue_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_coalescing_event_ring_queue_unit: self-checking bench for the event queue
// Drives commands on the input stream, predicts every result with a local
// queue model (ring indexes, motion coalescing scan, counters) and compares
// each output transfer field by field. Random idling on both sides plus one
// long output stall that backs the block up.
// ----------------------------------------------------------------------------
module tb_coalescing_event_ring_queue_unit;

  localparam int unsigned Depth = cerq_pkg::QueueDepthDefault;

  typedef struct packed {
    logic [63:0] dropped;
    logic [63:0] coalesced;
    logic [11:0] count;
    logic [63:0] ev_time;
    logic [15:0] ev_size;
    logic [31:0] ev_window;
    logic [7:0]  ev_type;
    logic [2:0]  status;
  } result_t;

  logic          clk_i;
  logic          rst_ni;
  logic          s_axis_tvalid;
  logic          s_axis_tready;
  logic [127:0]  s_axis_tdata;
  logic          m_axis_tvalid;
  logic          m_axis_tready;
  logic [263:0]  m_axis_tdata;
  logic          cfg_valid_i;
  logic          cfg_ready_o;
  logic [0:0]    cfg_index_i;
  logic [7:0]    cfg_data_i;

  coalescing_event_ring_queue_unit dut (.*);

  always begin
    clk_i = 1'b0; #5;
    clk_i = 1'b1; #5;
  end

  // queue model
  cerq_pkg::entry_t slots [Depth];
  int unsigned      wr_idx, rd_idx;
  logic [63:0]      n_coalesced, n_dropped;
  logic [7:0]       motion_code;
  logic             merge_en;
  result_t          expected_q[$];
  int               errors;
  bit               quiet;      // no random idling on either side
  int               hold_cycles;

  function automatic int unsigned occupancy();
    return (wr_idx + Depth - rd_idx) % Depth;
  endfunction

  function automatic result_t predict_command(cerq_pkg::cmd_e cmd, cerq_pkg::entry_t ev);
    result_t r;
    int unsigned i;
    bit done;
    r = '0;
    r.status = cerq_pkg::ST_DONE;
    case (cmd)
      cerq_pkg::CMD_PUSH: begin
        done = 1'b0;
        if (merge_en && ev.ev_type == motion_code && wr_idx != rd_idx) begin
          i = (wr_idx == 0) ? Depth - 1 : wr_idx - 1;
          while (!done && slots[i].ev_type == motion_code) begin
            if (slots[i].ev_window == ev.ev_window) begin
              slots[i] = ev;
              n_coalesced++;
              r.status = cerq_pkg::ST_COALESCED;
              done = 1'b1;
            end else if (i == rd_idx) begin
              break;
            end else begin
              i = (i == 0) ? Depth - 1 : i - 1;
            end
          end
        end
        if (!done) begin
          if ((wr_idx + 1) % Depth == rd_idx) begin
            n_dropped++;
            r.status = cerq_pkg::ST_DROPPED;
          end else begin
            slots[wr_idx] = ev;
            wr_idx = (wr_idx + 1) % Depth;
            r.status = cerq_pkg::ST_APPENDED;
          end
        end
      end
      cerq_pkg::CMD_POP: begin
        if (rd_idx == wr_idx) r.status = cerq_pkg::ST_EMPTY;
        else begin
          r.ev_type   = slots[rd_idx].ev_type;
          r.ev_window = slots[rd_idx].ev_window;
          r.ev_size   = slots[rd_idx].ev_size;
          r.ev_time   = slots[rd_idx].ev_time;
          rd_idx = (rd_idx + 1) % Depth;
          r.status = cerq_pkg::ST_POPPED;
        end
      end
      cerq_pkg::CMD_CLEAR: rd_idx = wr_idx;
      cerq_pkg::CMD_RSTCNT: begin
        n_coalesced = '0;
        n_dropped = '0;
      end
      default: ;
    endcase
    r.count = 12'(occupancy());
    r.coalesced = n_coalesced;
    r.dropped = n_dropped;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    errors++;
  endtask

  // sends one command; raw code lets unknown commands through.
  // tvalid stays high after the transfer until the next call or release_input
  task automatic send_command(logic [2:0] code, cerq_pkg::entry_t ev);
    s_axis_tdata  <= {5'd0, ev.ev_time, ev.ev_size, ev.ev_window, ev.ev_type, code};
    while (!quiet && $urandom_range(99) < 6) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_q.push_back(predict_command(cerq_pkg::cmd_e'(code), ev));
  endtask

  task automatic release_input();
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic write_reg(int unsigned idx, logic [7:0] val);
    release_input();
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    cfg_index_i <= idx[0:0];
    cfg_data_i  <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == cerq_pkg::RegMotionType) motion_code = val;
    else merge_en = val[0];
  endtask

  function automatic cerq_pkg::entry_t make_event(logic [7:0] t, logic [31:0] w);
    cerq_pkg::entry_t e;
    e.ev_type = t;
    e.ev_window = w;
    e.ev_size = 16'($urandom);
    e.ev_time = {$urandom, $urandom};
    return e;
  endfunction

  // output side: random stall, or one long hold-off when requested
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else m_axis_tready <= quiet || ($urandom_range(99) >= 6);
  end

  always @(posedge clk_i) begin
    result_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = result_t'(m_axis_tdata[262:0]);
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", 64'(got.status), 64'd0);
      end else begin
        want = expected_q.pop_front();
        if (got.status !== want.status)
          report_mismatch("status", 64'(got.status), 64'(want.status));
        if (got.ev_type !== want.ev_type)
          report_mismatch("type", 64'(got.ev_type), 64'(want.ev_type));
        if (got.ev_window !== want.ev_window)
          report_mismatch("window", 64'(got.ev_window), 64'(want.ev_window));
        if (got.ev_size !== want.ev_size)
          report_mismatch("size", 64'(got.ev_size), 64'(want.ev_size));
        if (got.ev_time !== want.ev_time) report_mismatch("time", got.ev_time, want.ev_time);
        if (got.count !== want.count)
          report_mismatch("count", 64'(got.count), 64'(want.count));
        if (got.coalesced !== want.coalesced)
          report_mismatch("coalesced", got.coalesced, want.coalesced);
        if (got.dropped !== want.dropped)
          report_mismatch("dropped", got.dropped, want.dropped);
      end
    end
  end

  task automatic test_directed();
    send_command(cerq_pkg::CMD_POP, '0);                // pop of empty queue
    send_command(cerq_pkg::CMD_PUSH, make_event(8'd1, 32'hFFFF_FFFF));
    send_command(cerq_pkg::CMD_PUSH, make_event(8'd1, 32'd0));
    send_command(cerq_pkg::CMD_PUSH, make_event(8'd1, 32'hFFFF_FFFF)); // merges past newer motion
    send_command(cerq_pkg::CMD_PUSH, make_event(8'd0, 32'd7));
    send_command(cerq_pkg::CMD_PUSH, make_event(8'd1, 32'd0)); // blocked by non-motion entry
    send_command(cerq_pkg::CMD_PUSH, {64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 32'd9, 8'hFF});
    send_command(cerq_pkg::CMD_STATUS, '0);
    send_command(3'd5, '0);
    send_command(3'd6, '0);
    send_command(3'd7, '1);
    repeat (3) send_command(cerq_pkg::CMD_POP, '0);
    send_command(cerq_pkg::CMD_RSTCNT, '0);
    send_command(cerq_pkg::CMD_CLEAR, '0);
    send_command(cerq_pkg::CMD_POP, '0);
  endtask

  task automatic test_config();
    write_reg(cerq_pkg::RegCoalesceEn, 8'd0);           // plain append of motion
    send_command(cerq_pkg::CMD_PUSH, make_event(8'd1, 32'd3));
    send_command(cerq_pkg::CMD_PUSH, make_event(8'd1, 32'd3));
    write_reg(cerq_pkg::RegMotionType, 8'hFF);
    write_reg(cerq_pkg::RegCoalesceEn, 8'd1);
    send_command(cerq_pkg::CMD_PUSH, make_event(8'hFF, 32'd3));
    send_command(cerq_pkg::CMD_PUSH, make_event(8'hFF, 32'd3));
    send_command(cerq_pkg::CMD_CLEAR, '0);
    write_reg(cerq_pkg::RegMotionType, 8'd0);
    send_command(cerq_pkg::CMD_PUSH, make_event(8'd0, 32'd1));
    send_command(cerq_pkg::CMD_PUSH, make_event(8'd0, 32'd1));
    send_command(cerq_pkg::CMD_CLEAR, '0);
    write_reg(cerq_pkg::RegMotionType, 8'd1);
  endtask

  // motion-heavy pushes over few windows so scans run deep
  task automatic test_random(int n);
    logic [2:0] code;
    logic [7:0] t;
    for (int k = 0; k < n; k++) begin
      quiet = (k >= n / 3 && k < n / 2);
      case ($urandom_range(19))
        0,1,2,3,4,5,6,7,8,9: code = cerq_pkg::CMD_PUSH;
        10,11,12,13,14: code = cerq_pkg::CMD_POP;
        15: code = cerq_pkg::CMD_CLEAR;
        16: code = cerq_pkg::CMD_RSTCNT;
        17: code = cerq_pkg::CMD_STATUS;
        default: code = 3'($urandom_range(7));
      endcase
      t = ($urandom_range(3) != 0) ? motion_code : 8'($urandom);
      if (code == cerq_pkg::CMD_PUSH)
        send_command(code, make_event(t, ($urandom_range(3) == 0) ? $urandom
                                                                   : $urandom_range(5)));
      else send_command(code, make_event(8'($urandom), $urandom));
    end
    quiet = 1'b0;
  endtask

  task automatic test_backpressure();
    hold_cycles = 400;
    repeat (40) send_command(cerq_pkg::CMD_PUSH, make_event(8'($urandom), $urandom));
    repeat (40) send_command(cerq_pkg::CMD_POP, '0);
  endtask

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    errors = 0;
    quiet = 1'b0;
    hold_cycles = 0;
    wr_idx = 0;
    rd_idx = 0;
    n_coalesced = '0;
    n_dropped = '0;
    motion_code = 8'd1;
    merge_en = 1'b1;
    foreach (slots[i]) slots[i] = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_config();
    test_random(150);
    test_backpressure();
    write_reg(cerq_pkg::RegCoalesceEn, 8'd0);
    test_random(80);
    write_reg(cerq_pkg::RegCoalesceEn, 8'd1);
    test_random(80);
    release_input();
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (errors == 0) $display("[coalescing_event_ring_queue_unit] OK");
    else $display("[coalescing_event_ring_queue_unit] ERROR");
    $finish;
  end

  initial begin
    #20ms;
    $display("[coalescing_event_ring_queue_unit] ERROR");
    $finish;
  end

endmodule
